// ----- hw/rtl/fics_pkg.sv -----
// ----------------------------------------------------------------------------
// fics_pkg: shared types and constants of the framed I/O command slave
// Frame codes, parser phases, CRC-16/MODBUS byte update, inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package fics_pkg;

    localparam logic [7:0]  MARK      = 8'hFE;
    localparam logic [7:0]  CMD_WRITE = 8'h01;
    localparam logic [7:0]  CMD_READ  = 8'h02;
    localparam logic [7:0]  LEN_WRITE = 8'h05;   // frame length of a valid write
    localparam logic [7:0]  LEN_READ  = 8'h04;   // frame length of a valid read
    localparam logic [7:0]  RLEN_WR   = 8'h04;   // length byte of the write reply
    localparam logic [7:0]  RLEN_RD   = 8'h05;   // length byte of the read reply
    localparam logic [7:0]  ACK       = 8'h01;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    localparam logic [2:0]  BODY_WR   = 3'd5;    // reply body bytes, write
    localparam logic [2:0]  BODY_RD   = 3'd6;    // reply body bytes, read

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_CMD   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRCH  = 3'd5,
        PH_CRCL  = 3'd6
    } t_phase;

    // Reply request from parser to reply unit
    typedef struct packed {
        logic        load;
        logic        is_read;
        logic [7:0]  pin;
        logic        lvl;
        logic [15:0] levels;
    } t_reply_req;

    // Reply unit status back to parser
    typedef struct packed {
        logic can_load;
    } t_reply_stat;

    // One byte through CRC-16/MODBUS, LSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    localparam logic [15:0] CRC_HDR = crc_feed(crc_feed(CRC_INIT, MARK), MARK);

endpackage

`default_nettype wire

// ----- hw/rtl/fics_parser.sv -----
// ----------------------------------------------------------------------------
// fics_parser: receive-side frame parser and pin register
// Hunts header, tracks CRC per byte, runs commands on a good frame.
// ----------------------------------------------------------------------------
`default_nettype none

module fics_parser
    import fics_pkg::*;
#(
    parameter int NUM_PINS  = 16,
    parameter int MAX_FRAME = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_burst_end,
    input  wire logic [15:0] i_input_levels,
    input  wire t_reply_stat i_stat,
    output      t_reply_req  o_req
);

    t_phase              r_phase,      n_phase;
    logic [7:0]          r_bytes_left, n_bytes_left;
    logic [15:0]         r_crc,        n_crc;
    logic [7:0]          r_cmd,        n_cmd;
    logic [7:0]          r_len,        n_len;
    logic [7:0]          r_pin_idx,    n_pin_idx;
    logic [7:0]          r_pin_val,    n_pin_val;
    logic [7:0]          r_crc_hi,     n_crc_hi;
    logic [NUM_PINS-1:0] r_pins,       n_pins;
    logic [15:0]         w_levels_next;
    logic                w_accept;

    // A reply can only start on the last CRC byte
    assign o_ready  = (r_phase != PH_CRCL) || i_stat.can_load;
    assign w_accept = i_valid && o_ready;

    for (genvar k = 0; k < 16; k++) begin : g_view
        if (k < NUM_PINS) begin : g_on
            assign w_levels_next[k] = n_pins[k];
        end else begin : g_off
            assign w_levels_next[k] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT1;
            r_bytes_left <= '0;
            r_crc        <= CRC_INIT;
            r_cmd        <= '0;
            r_len        <= '0;
            r_pin_idx    <= '0;
            r_pin_val    <= '0;
            r_crc_hi     <= '0;
            r_pins       <= '0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_cmd        <= n_cmd;
            r_len        <= n_len;
            r_pin_idx    <= n_pin_idx;
            r_pin_val    <= n_pin_val;
            r_crc_hi     <= n_crc_hi;
            r_pins       <= n_pins;
        end
    end

    always_comb begin
        logic crc_ok;
        logic lvl;
        logic do_wr;
        logic do_rd;
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_cmd        = r_cmd;
        n_len        = r_len;
        n_pin_idx    = r_pin_idx;
        n_pin_val    = r_pin_val;
        n_crc_hi     = r_crc_hi;
        n_pins       = r_pins;
        crc_ok       = (r_crc_hi == r_crc[15:8]) && (i_rx_byte == r_crc[7:0]);
        do_wr        = 1'b0;
        do_rd        = 1'b0;
        lvl          = 1'b0;

        unique case (r_phase)
            PH_HUNT2: begin
                if (i_rx_byte == MARK) begin
                    n_crc   = CRC_HDR;
                    n_phase = PH_LEN;
                end else begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_LEN: begin
                if ((i_rx_byte < 8'd3) || (({1'b0, i_rx_byte} + 9'd3) > 9'(MAX_FRAME))) begin
                    n_phase = PH_HUNT1;
                end else begin
                    n_len   = i_rx_byte;
                    n_crc   = crc_feed(r_crc, i_rx_byte);
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                n_cmd        = i_rx_byte;
                n_crc        = crc_feed(r_crc, i_rx_byte);
                n_pin_idx    = '0;
                n_pin_val    = '0;
                n_bytes_left = r_len - 8'd3;
                n_phase      = (r_len == 8'd3) ? PH_CRCH : PH_DATA;
            end
            PH_DATA: begin
                n_crc = crc_feed(r_crc, i_rx_byte);
                // position in data field: first byte is pin, second is level
                if (r_bytes_left == (r_len - 8'd3)) begin
                    n_pin_idx = i_rx_byte;
                end else if (r_bytes_left == (r_len - 8'd4)) begin
                    n_pin_val = i_rx_byte;
                end
                n_bytes_left = r_bytes_left - 8'd1;
                if (r_bytes_left == 8'd1) begin
                    n_phase = PH_CRCH;
                end
            end
            PH_CRCH: begin
                n_crc_hi = i_rx_byte;
                n_phase  = PH_CRCL;
            end
            PH_CRCL: begin
                n_phase = PH_HUNT1;
                if (crc_ok) begin
                    do_wr = (r_cmd == CMD_WRITE) && (r_len == LEN_WRITE);
                    do_rd = (r_cmd == CMD_READ)  && (r_len == LEN_READ);
                end
                if (do_wr) begin
                    for (int k = 0; k < NUM_PINS; k++) begin
                        if (r_pin_idx == 8'(k + 1)) begin
                            n_pins[k] = (r_pin_val != 8'd0);
                        end
                    end
                end
                for (int k = 0; k < 16; k++) begin
                    if ((k < NUM_PINS) && (r_pin_idx == 8'(k + 1))) begin
                        lvl = i_input_levels[k];
                    end
                end
            end
            default: begin
                // header hunt, also any unused code
                n_phase = (i_rx_byte == MARK) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase

        if (i_burst_end) begin
            n_phase = PH_HUNT1;
        end

        o_req.load    = w_accept && (do_wr || do_rd);
        o_req.is_read = do_rd;
        o_req.pin     = r_pin_idx;
        o_req.lvl     = lvl;
        o_req.levels  = w_levels_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fics_reply.sv -----
// ----------------------------------------------------------------------------
// fics_reply: reply frame serializer
// Emits reply body bytes, folding each into the CRC, then CRC high and low.
// ----------------------------------------------------------------------------
`default_nettype none

module fics_reply
    import fics_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_reply_req  i_req,
    output      t_reply_stat o_stat,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [7:0]  o_tx_byte,
    output      logic        o_tx_last,
    output      logic [15:0] o_levels
);

    logic        r_busy;
    logic [2:0]  r_idx;
    logic [15:0] r_crc;
    logic        r_is_read;
    logic [7:0]  r_pin;
    logic        r_lvl;
    logic [15:0] r_levels;
    logic [2:0]  w_body;
    logic        w_take;

    assign w_body          = r_is_read ? BODY_RD : BODY_WR;
    assign o_valid         = r_busy;
    assign o_tx_last       = (r_idx == (w_body + 3'd1));
    assign o_levels        = r_levels;
    assign w_take          = r_busy && i_ready;
    assign o_stat.can_load = !r_busy || (w_take && o_tx_last);

    always_comb begin
        unique case (r_idx)
            3'd0, 3'd1: o_tx_byte = MARK;
            3'd2:       o_tx_byte = r_is_read ? RLEN_RD : RLEN_WR;
            3'd3:       o_tx_byte = r_is_read ? CMD_READ : CMD_WRITE;
            3'd4:       o_tx_byte = r_is_read ? r_pin : ACK;
            default: begin
                if (r_idx < w_body) begin
                    o_tx_byte = {7'd0, r_lvl};
                end else if (r_idx == w_body) begin
                    o_tx_byte = r_crc[15:8];
                end else begin
                    o_tx_byte = r_crc[7:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_crc  <= CRC_INIT;
        end else if (i_req.load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_crc  <= CRC_INIT;
        end else if (w_take) begin
            if (o_tx_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
                if (r_idx < w_body) begin
                    r_crc <= crc_feed(r_crc, o_tx_byte);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            r_is_read <= i_req.is_read;
            r_pin     <= i_req.pin;
            r_lvl     <= i_req.lvl;
            r_levels  <= i_req.levels;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/framed_io_command_slave.sv -----
// ----------------------------------------------------------------------------
// framed_io_command_slave: byte-stream command slave with CRC-16/MODBUS
// Reply start: a reply's first byte is valid in the cycle after the last CRC byte is accepted.
// Throughput: one received byte per cycle; a reply is 7 (write) or 8 (read)
//   bytes at one per cycle while the reply stream is ready, and the final CRC
//   byte of the next frame waits while a reply is still draining.
// Reset: synchronous active-low; parser to header hunt, pins low, no reply.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_io_command_slave
    import fics_pkg::*;
#(
    parameter int NUM_PINS  = 16,   // 1..64, pins beyond 16 are not visible
    parameter int MAX_FRAME = 128   // 8..255, longest frame length plus 3
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // received byte stream
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // [7:0] rx_byte, [23:8] input_levels
    input  wire logic        i_s_axis_tlast,   // burst_end
    // reply byte stream
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output      logic [23:0] o_m_axis_tdata,   // [7:0] tx_byte, [23:8] output_levels
    output      logic        o_m_axis_tlast    // tx_last
);

    t_reply_req  w_req;
    t_reply_stat w_stat;
    logic [7:0]  w_tx_byte;
    logic [15:0] w_levels;

    // Parser: one transaction per cycle; the only stall is the closing CRC
    // byte of a frame while the previous reply still occupies the serializer.
    fics_parser #(
        .NUM_PINS  (NUM_PINS),
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_rx_byte      (i_s_axis_tdata[7:0]),
        .i_burst_end    (i_s_axis_tlast),
        .i_input_levels (i_s_axis_tdata[23:8]),
        .i_stat         (w_stat),
        .o_req          (w_req)
    );

    // Serializer: holds the reply fields and a running CRC; pin levels are
    // snapshot at load so every byte of a reply carries the same value.
    fics_reply u_reply (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_stat    (w_stat),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_tx_byte (w_tx_byte),
        .o_tx_last (o_m_axis_tlast),
        .o_levels  (w_levels)
    );

    assign o_m_axis_tdata = {w_levels, w_tx_byte};

endmodule

`default_nettype wire

// ----- hw/rtl/fics_checker.sv -----
// ----------------------------------------------------------------------------
// fics_checker: port-level checks of the framed I/O command slave
// Reset behavior, reply framing and level consistency within a reply.
// ----------------------------------------------------------------------------
`default_nettype none

module fics_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,
    input  wire logic        i_s_axis_tlast,
    input  wire logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [23:0] o_m_axis_tdata,
    input  wire logic        o_m_axis_tlast
);

    // no reply comes out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("reply valid right after reset");

    // a stalled reply byte holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("reply byte changed while stalled");

    // a new reply starts with the header mark
    a_new_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast
        |=> !o_m_axis_tvalid || (o_m_axis_tdata[7:0] == 8'hFE))
        else $error("reply does not start with header");

    // a reply runs without gaps and carries one pin snapshot
    a_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast
        |=> o_m_axis_tvalid && (o_m_axis_tdata[23:8] == $past(o_m_axis_tdata[23:8])))
        else $error("reply broken or pin levels changed mid-reply");

endmodule

bind framed_io_command_slave fics_checker u_fics_checker (.*);

`default_nettype wire
